/* src/assert_macros.svh */
// assertion macros used by the relay controller top-level file
// no dependencies; expects clk_i and rst_ni in scope for the default form
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define VRAC_ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("relay control assertion failed");

// concurrent assertion on the block clock and reset
`define VRAC_ASSERT(lbl, prop) \
  `VRAC_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`endif

/* src/vrac_pkg.sv */
// types, constants and register codes of the voltage relay controller
// no dependencies; used by every module of the block

package vrac_pkg;

  // decision history depth
  localparam int unsigned HistDepth = 4;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] REG_MODE      = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_HOLD      = 2'd2;

  // register reset values
  localparam logic [15:0] ThresholdReset = 16'(858 * 4);
  localparam logic [7:0]  HoldReset      = 8'd90;

  // relay modes
  typedef enum logic [1:0] {
    MODE_OFF  = 2'd0,
    MODE_ON   = 2'd1,
    MODE_AUTO = 2'd2
  } relay_mode_e;

  // history entry codes
  typedef enum logic [1:0] {
    HIST_OFF   = 2'd0,
    HIST_ON    = 2'd1,
    HIST_EMPTY = 2'd2
  } hist_code_e;

  // input transaction
  typedef struct packed {
    logic [31:0] now_sec;
    logic [15:0] voltage;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic relay_drive;
    logic reported_state;
    logic auto_decision;
    logic switched;
  } out_item_t;

  // live register values
  typedef struct packed {
    relay_mode_e mode;
    logic [15:0] on_threshold;
    logic [7:0]  hold_seconds;
  } cfg_t;

  // side effects of a register write on the controller state
  typedef struct packed {
    logic hist_clr;
    logic force_drive;
    logic force_val;
  } cfg_evt_t;

endpackage

/* src/vrac_cfg_regs.sv */
// configuration registers: mode, on threshold and hold time
// depends on vrac_pkg

module vrac_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [vrac_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [vrac_pkg::CfgDataW-1:0] cfg_wdata_i,
  output vrac_pkg::cfg_t                cfg_o,
  output vrac_pkg::cfg_evt_t            evt_o
);

  vrac_pkg::cfg_t     cfg_q, cfg_d;
  vrac_pkg::cfg_evt_t evt;

  // decode a write into new register values and state events
  always_comb begin
    cfg_d = cfg_q;
    evt   = '0;
    if (cfg_we_i) begin
      case (cfg_index_i)
        vrac_pkg::REG_MODE: begin
          case (cfg_wdata_i[1:0])
            vrac_pkg::MODE_AUTO: begin
              cfg_d.mode   = vrac_pkg::MODE_AUTO;
              evt.hist_clr = 1'b1;
            end
            vrac_pkg::MODE_ON: begin
              cfg_d.mode      = vrac_pkg::MODE_ON;
              evt.force_drive = 1'b1;
              evt.force_val   = 1'b1;
            end
            default: begin
              // off and the unused code both force the relay off
              cfg_d.mode      = vrac_pkg::MODE_OFF;
              evt.force_drive = 1'b1;
              evt.force_val   = 1'b0;
            end
          endcase
        end
        vrac_pkg::REG_THRESHOLD: begin
          cfg_d.on_threshold = cfg_wdata_i[15:0];
          evt.hist_clr       = 1'b1;
        end
        vrac_pkg::REG_HOLD: begin
          cfg_d.hold_seconds = cfg_wdata_i[7:0];
        end
        default: begin
          // index beyond the register list is ignored
        end
      endcase
    end
  end

  // register storage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode         <= vrac_pkg::MODE_OFF;
      cfg_q.on_threshold <= vrac_pkg::ThresholdReset;
      cfg_q.hold_seconds <= vrac_pkg::HoldReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
  assign evt_o = evt;

endmodule

/* src/vrac_core.sv */
// controller state and single-pass tick logic: hold check, threshold
// decision, history consensus and relay switching; depends on vrac_pkg

module vrac_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  vrac_pkg::in_item_t  item_i,
  input  vrac_pkg::cfg_t      cfg_i,
  input  vrac_pkg::cfg_evt_t  evt_i,
  output vrac_pkg::out_item_t res_o
);

  vrac_pkg::hist_code_e hist_q [vrac_pkg::HistDepth];
  vrac_pkg::hist_code_e hist_d [vrac_pkg::HistDepth];
  logic                 adopted_q, adopted_d;
  logic [31:0]          last_sw_q, last_sw_d;
  logic                 drive_q, drive_d;
  logic                 reported_d;

  logic                 holding;
  logic                 dec;
  vrac_pkg::hist_code_e dec_code;
  logic                 agree;
  logic                 adopt;
  logic                 sw;
  logic [31:0]          elapsed;

  // hold window after a switch while the adopted decision is on
  assign elapsed = item_i.now_sec - last_sw_q;
  assign holding = adopted_q && (elapsed < {24'd0, cfg_i.hold_seconds});

  // threshold decision
  assign dec      = (item_i.voltage >= cfg_i.on_threshold);
  assign dec_code = dec ? vrac_pkg::HIST_ON : vrac_pkg::HIST_OFF;

  // shifted history and consensus
  always_comb begin
    for (int i = 0; i < int'(vrac_pkg::HistDepth) - 1; i++) begin
      hist_d[i] = hist_q[i+1];
    end
    hist_d[vrac_pkg::HistDepth-1] = dec_code;
    agree = 1'b1;
    for (int i = 0; i < int'(vrac_pkg::HistDepth); i++) begin
      if (hist_d[i] != dec_code) agree = 1'b0;
    end
  end

  // adoption and relay switching; the reported state is the drive before the tick
  assign adopt      = !holding && agree;
  assign adopted_d  = adopt ? dec : adopted_q;
  assign sw         = adopt && (cfg_i.mode == vrac_pkg::MODE_AUTO) && (dec != drive_q);
  assign drive_d    = sw ? dec : drive_q;
  assign reported_d = drive_q;
  assign last_sw_d  = sw ? item_i.now_sec : last_sw_q;

  // result of this tick
  assign res_o.relay_drive    = drive_d;
  assign res_o.reported_state = reported_d;
  assign res_o.auto_decision  = adopted_d;
  assign res_o.switched       = sw;

  // state update: register writes, else a processed tick
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(vrac_pkg::HistDepth); i++) begin
        hist_q[i] <= vrac_pkg::HIST_EMPTY;
      end
      adopted_q <= 1'b0;
      last_sw_q <= '0;
      drive_q   <= 1'b0;
    end else if (evt_i.hist_clr || evt_i.force_drive) begin
      if (evt_i.hist_clr) begin
        for (int i = 0; i < int'(vrac_pkg::HistDepth); i++) begin
          hist_q[i] <= vrac_pkg::HIST_EMPTY;
        end
      end
      if (evt_i.force_drive) begin
        drive_q <= evt_i.force_val;
      end
    end else if (step_i) begin
      if (!holding) begin
        for (int i = 0; i < int'(vrac_pkg::HistDepth); i++) begin
          hist_q[i] <= hist_d[i];
        end
      end
      adopted_q <= adopted_d;
      last_sw_q <= last_sw_d;
      drive_q   <= drive_d;
    end
  end

endmodule

/* src/voltage_relay_auto_control.sv */
// top level of the voltage relay controller: input register, tick logic,
// result register; depends on vrac_pkg, vrac_cfg_regs, vrac_core

//  channel | signals                              | payload
//  --------+--------------------------------------+---------------------
//  in      | in_valid_i / in_ready_o              | in_item_i (now, volt)
//  out     | out_valid_o / out_ready_i            | out_item_o (4 flags)
//  config  | cfg_we_i, cfg_index_i, cfg_wdata_i   | one register a write
//
// a tick sits in the input register, then the whole decision runs in one
// pass and lands in the result register; out_valid_o rises when the tick
// moves from the input register into the result register.
// a new tick is taken every cycle unless the result register is held by
// out_ready_i low and the input register is full.
// reset clears all control state at once; no clearing pass.

`include "assert_macros.svh"

module voltage_relay_auto_control (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  vrac_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output vrac_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [vrac_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [vrac_pkg::CfgDataW-1:0] cfg_wdata_i
);

  logic                in_valid_q;
  vrac_pkg::in_item_t  in_item_q;
  logic                out_valid_q;
  vrac_pkg::out_item_t out_item_q;
  logic                advance;
  vrac_pkg::cfg_t      cfg;
  vrac_pkg::cfg_evt_t  evt;
  vrac_pkg::out_item_t res;

  // handshake control
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // registers
  vrac_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg),
    .evt_o       (evt)
  );

  // tick logic and state
  vrac_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .evt_i  (evt),
    .res_o  (res)
  );

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_item_q <= in_item_i;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // checks
  `VRAC_ASSERT(a_sw_only_auto, advance && res.switched |-> cfg.mode == vrac_pkg::MODE_AUTO)
  `VRAC_ASSERT(a_sw_marks_change, advance |-> res.switched == (res.relay_drive ^ res.reported_state))
  `VRAC_ASSERT(a_empty_takes, !in_valid_q |-> in_ready_o)
  `VRAC_ASSERT(a_result_held, out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_item_q))

endmodule

/* verif/voltage_relay_auto_control_tb.sv */
// testbench for the voltage relay controller: directed and random ticks,
// checked against a cycle-free prediction of relay drive, report, decision and switch flag
// depends on vrac_pkg and voltage_relay_auto_control
`timescale 1ns / 1ps

module voltage_relay_auto_control_tb;
  import vrac_pkg::*;

  localparam int unsigned RandomTicks  = 600;
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 4;
  // register index past the end of the list, and the unused mode code
  localparam logic [CfgIdxW-1:0] REG_SPARE  = 2'd3;
  localparam logic [1:0]         MODE_SPARE = 2'd3;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                tick_valid = 1'b0;
  logic                tick_ready;
  in_item_t            tick_item = '0;
  logic                res_valid;
  logic                res_ready = 1'b0;
  out_item_t           res_item;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // predicted controller state and registers
  hist_code_e  hist_q [HistDepth];
  logic        adopted_q = 1'b0;
  logic [31:0] last_switch_q = '0;
  logic        drive_q = 1'b0;
  logic        reported_q = 1'b0;
  relay_mode_e mode_q = MODE_OFF;
  logic [15:0] thr_q = ThresholdReset;
  logic [7:0]  hold_q = HoldReset;

  out_item_t pending_relay_q [$];
  int        errors = 0;
  int        cycles = 0;
  bit        in_calm = 1'b0;
  bit        out_calm = 1'b0;
  int        stall_left = 0;

  voltage_relay_auto_control DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (tick_valid),
    .in_ready_o  (tick_ready),
    .in_item_i   (tick_item),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .out_item_o  (res_item),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_idx),
    .cfg_wdata_i (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stalls: mostly short, a few long, with calm stretches
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) out_calm = !out_calm;
    if (stall_left > 0) begin
      res_ready <= 1'b0;
      stall_left--;
    end else begin
      res_ready <= 1'b1;
      if (!out_calm && $urandom_range(0, 5) == 0) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
      end
    end
  end

  function automatic void hist_clear();
    foreach (hist_q[i]) hist_q[i] = HIST_EMPTY;
  endfunction

  // register write side effects
  function automatic void cfg_apply(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    case (idx)
      REG_MODE: begin
        case (data[1:0])
          MODE_AUTO: begin
            mode_q = MODE_AUTO;
            hist_clear();
          end
          MODE_ON: begin
            mode_q     = MODE_ON;
            drive_q    = 1'b1;
            reported_q = 1'b1;
          end
          default: begin
            mode_q     = MODE_OFF;
            drive_q    = 1'b0;
            reported_q = 1'b0;
          end
        endcase
      end
      REG_THRESHOLD: begin
        thr_q = data[15:0];
        hist_clear();
      end
      REG_HOLD: hold_q = data[7:0];
      default: ;
    endcase
  endfunction

  // one tick: sample unless holding, consensus over history, auto switching
  function automatic out_item_t predict_relay_tick(in_item_t it);
    out_item_t  r;
    logic [31:0] elapsed;
    hist_code_e code;
    logic       agree;
    logic       took;
    elapsed    = it.now_sec - last_switch_q;
    took       = 1'b0;
    r.switched = 1'b0;
    if (!(adopted_q && elapsed < 32'(hold_q))) begin
      code = (it.voltage >= thr_q) ? HIST_ON : HIST_OFF;
      for (int i = 0; i < HistDepth - 1; i++) hist_q[i] = hist_q[i + 1];
      hist_q[HistDepth - 1] = code;
      agree = 1'b1;
      foreach (hist_q[i]) if (hist_q[i] != code) agree = 1'b0;
      if (agree) begin
        adopted_q = (code == HIST_ON);
        took      = 1'b1;
      end
    end
    reported_q = drive_q;
    if (took && mode_q == MODE_AUTO && adopted_q != drive_q) begin
      last_switch_q = it.now_sec;
      drive_q       = adopted_q;
      r.switched    = 1'b1;
    end
    r.relay_drive    = drive_q;
    r.reported_state = reported_q;
    r.auto_decision  = adopted_q;
    return r;
  endfunction

  function automatic int in_gap();
    int r;
    r = $urandom_range(0, 99);
    if (in_calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // sample voltage on the requested side of the threshold
  function automatic logic [15:0] volt_for(logic on);
    if (on) return 16'($urandom_range(32'(thr_q), 32'hFFFF));
    if (thr_q == '0) return 16'($urandom);
    return 16'($urandom_range(0, 32'(thr_q) - 1));
  endfunction

  // send one tick transaction and predict its result on acceptance
  task automatic send_tick(logic [31:0] now, logic [15:0] volt);
    int       gap;
    in_item_t it;
    gap = in_gap();
    it  = '{now_sec: now, voltage: volt};
    if (gap > 0) begin
      @(negedge clk);
      tick_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    tick_valid <= 1'b1;
    tick_item  <= it;
    do @(posedge clk); while (!tick_ready);
    pending_relay_q.push_back(predict_relay_tick(it));
  endtask

  // stop sending and wait until every result has come back
  task automatic drain_results();
    @(negedge clk);
    tick_valid <= 1'b0;
    while (pending_relay_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_apply(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic check_flag(string name, logic exp_v, logic act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      errors++;
    end
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && res_valid && res_ready) begin
      if (pending_relay_q.size() == 0) begin
        $error("result transaction with none pending: %b", res_item);
        errors++;
      end else begin
        want = pending_relay_q.pop_front();
        check_flag("relay_drive", want.relay_drive, res_item.relay_drive);
        check_flag("reported_state", want.reported_state, res_item.reported_state);
        check_flag("auto_decision", want.auto_decision, res_item.auto_decision);
        check_flag("switched", want.switched, res_item.switched);
      end
    end
  end

  // forced modes, the unused mode code, a write past the register list
  task automatic test_forced_modes();
    send_tick(32'h0, 16'h0);
    drain_results();
    write_reg(REG_MODE, {14'h0, MODE_ON});
    send_tick(32'hFFFF_FFFF, 16'hFFFF);
    drain_results();
    write_reg(REG_MODE, {14'h3FFF, MODE_SPARE});
    write_reg(REG_SPARE, 16'hFFFF);
    // history fills and adopts on while the relay stays forced off
    send_tick(32'd1, 16'hFFFF);
    send_tick(32'd2, 16'hFFFF);
    send_tick(32'd3, 16'hFFFF);
  endtask

  // consensus switching, hold time, threshold edge, elapsed time wrap
  task automatic test_auto_switching();
    drain_results();
    write_reg(REG_THRESHOLD, 16'd1000);
    write_reg(REG_HOLD, 16'd3);
    write_reg(REG_MODE, {14'h0, MODE_AUTO});
    for (int t = 100; t < 104; t++) send_tick(32'(t), 16'd1000);
    send_tick(32'd104, 16'd0);
    send_tick(32'd105, 16'd0);
    for (int t = 106; t < 110; t++) send_tick(32'(t), 16'd999);
    drain_results();
    write_reg(REG_THRESHOLD, 16'hFFFF);
    write_reg(REG_HOLD, 16'h0);
    send_tick(32'hFFFF_FFFE, 16'hFFFF);
    send_tick(32'hFFFF_FFFF, 16'hFFFF);
    send_tick(32'd0, 16'hFFFF);
    send_tick(32'd1, 16'hFFFF);
    drain_results();
    write_reg(REG_HOLD, 16'hA5FF);
    send_tick(32'd2, 16'd0);
    // now behind the last switch: elapsed wraps to a huge value
    send_tick(32'd0, 16'd0);
    drain_results();
    write_reg(REG_THRESHOLD, 16'h0);
    send_tick(32'd500, 16'd0);
  endtask

  task automatic random_config();
    logic [1:0] m;
    int         r;
    r = $urandom_range(0, 99);
    m = (r < 70) ? MODE_AUTO : (r < 80) ? MODE_ON : (r < 90) ? MODE_OFF : MODE_SPARE;
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 99);
      write_reg(REG_THRESHOLD, (r < 10) ? 16'h0 : (r < 20) ? 16'hFFFF : 16'($urandom));
    end
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 99);
      write_reg(REG_HOLD, {8'($urandom),
                (r < 10) ? 8'h0 : (r < 20) ? 8'hFF : (r < 80) ? 8'($urandom_range(1, 8))
                                                           : 8'($urandom)});
    end
    if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, 16'($urandom));
    write_reg(REG_MODE, {14'($urandom), m});
  endtask

  // phases of random settings; voltage in runs on one side of the threshold
  task automatic test_random_ticks();
    int          sent;
    int          len;
    int          run;
    int          r;
    logic        want_on;
    logic [31:0] now;
    logic [15:0] volt;
    sent    = 0;
    now     = $urandom;
    want_on = 1'b0;
    while (sent < RandomTicks) begin
      drain_results();
      random_config();
      in_calm = ($urandom_range(0, 3) == 0);
      len     = $urandom_range(20, 60);
      run     = 0;
      for (int k = 0; k < len; k++) begin
        r = $urandom_range(0, 99);
        if (r < 85) now = now + 1;
        else if (r < 95) now = now + $urandom_range(2, 300);
        else if (r < 98) now = $urandom;
        else now = 32'hFFFF_FFFF - $urandom_range(0, 20);
        if (run == 0) begin
          want_on = !want_on;
          run     = $urandom_range(1, 10);
        end
        run--;
        volt = ($urandom_range(0, 9) == 0) ? 16'($urandom) : volt_for(want_on);
        send_tick(now, volt);
        sent++;
      end
    end
  endtask

  initial begin
    hist_clear();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_forced_modes();
    test_auto_switching();
    test_random_ticks();
    drain_results();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+src
src/vrac_pkg.sv
src/vrac_cfg_regs.sv
src/vrac_core.sv
src/voltage_relay_auto_control.sv
verif/voltage_relay_auto_control_tb.sv
